>>> rtl/core/hgp_pkg.sv
package hgp_pkg;

  // Fixed geometry of the equation system
  localparam int unsigned MaxVars  = 1024;
  localparam int unsigned MaxEqs   = 1024;
  localparam int unsigned Slots    = 3;
  localparam int unsigned QDepth   = MaxVars + 1;
  localparam int unsigned IdW      = 10;
  localparam int unsigned CntW     = 11;
  localparam int unsigned DegW     = 12;

  // Request codes
  localparam logic [2:0] ReqClear    = 3'd0;
  localparam logic [2:0] ReqLoad     = 3'd1;
  localparam logic [2:0] ReqPeel     = 3'd2;
  localparam logic [2:0] ReqRdPeeled = 3'd3;
  localparam logic [2:0] ReqRdUnpeel = 3'd4;

  // Status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StIdxRange = 2'd2;
  localparam logic [1:0] StVarRange = 2'd3;

  typedef enum logic [4:0] {
    S_BOOT, S_IDLE, S_CLR, S_LD_CHK, S_RDW, S_RESP,
    S_PZ, S_B_LO, S_B_EQ, S_B_VL, S_B_RD, S_B_WR,
    S_SC, S_SC_CK, S_Q_POP, S_Q_V, S_Q_CK,
    S_P_VL, S_P_RD, S_P_WR, S_E_RD, S_E_CK,
    S_U_LO, S_U_FL, S_U_CK
  } hgp_state_e;

  typedef struct packed {
    logic [1:0]      status;
    logic [CntW-1:0] peeled_count;
    logic [CntW-1:0] unpeeled_count;
    logic [IdW-1:0]  equation_out;
    logic [IdW-1:0]  variable_out;
  } hgp_res_t;

endpackage

>>> rtl/core/hgp_core.sv
module hgp_core import hgp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] var_lim_i,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  logic [2:0]      req_type_i,
  input  logic [IdW-1:0]  equation_number_i,
  input  logic [IdW-1:0]  var_a_i,
  input  logic [IdW-1:0]  var_b_i,
  input  logic [IdW-1:0]  var_c_i,
  input  logic [IdW-1:0]  entry_index_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output hgp_res_t        res_o
);

  localparam int unsigned VmW = DegW + IdW;

  hgp_state_e state_q, state_d;

  logic [CntW-1:0] i_q, i_d, n_q, n_d, v_q, v_d;
  logic [CntW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] lc_q, lc_d, sc_q, sc_d, ut_q, ut_d;
  logic [1:0]      k_q, k_d;
  logic [IdW-1:0]  e_q, e_d, qv_q, qv_d;
  logic [Slots-1:0][IdW-1:0] vars_q, vars_d;
  logic [2:0]      req_q, req_d;
  logic [1:0]      st_q, st_d;
  logic [IdW-1:0]  eq_q, eq_d, var_q, var_d;

  // Memories and their ports
  logic [Slots*IdW-1:0] eqv_mem [MaxEqs];
  logic                 pres_mem [MaxEqs];
  logic [IdW-1:0]       lo_mem [MaxEqs];
  logic [VmW-1:0]       var_mem [MaxVars];
  logic                 pf_mem [MaxEqs];
  logic [IdW-1:0]       q_mem [QDepth];
  logic [2*IdW-1:0]     stk_mem [MaxEqs];
  logic [IdW-1:0]       unp_mem [MaxEqs];

  logic eqv_we, pres_we, pres_wd, lo_we, var_we, pf_we, pf_wd, q_we, stk_we, unp_we;
  logic [IdW-1:0] eqv_wa, eqv_ra, pres_wa, pres_ra, lo_wa, lo_ra, var_wa, var_ra;
  logic [IdW-1:0] pf_wa, pf_ra, stk_wa, stk_ra, unp_wa, unp_ra, lo_wd, q_wd, unp_wd;
  logic [CntW-1:0] q_wa, q_ra;
  logic [Slots*IdW-1:0] eqv_wd, eqv_rd;
  logic [VmW-1:0] var_wd, var_rd;
  logic [2*IdW-1:0] stk_wd, stk_rd;
  logic pres_rd, pf_rd;
  logic [IdW-1:0] lo_rd, q_rd, unp_rd;

  always_ff @(posedge clk_i) begin
    if (eqv_we) eqv_mem[eqv_wa] <= eqv_wd;
    eqv_rd <= eqv_mem[eqv_ra];
    if (pres_we) pres_mem[pres_wa] <= pres_wd;
    pres_rd <= pres_mem[pres_ra];
    if (lo_we) lo_mem[lo_wa] <= lo_wd;
    lo_rd <= lo_mem[lo_ra];
    if (var_we) var_mem[var_wa] <= var_wd;
    var_rd <= var_mem[var_ra];
    if (pf_we) pf_mem[pf_wa] <= pf_wd;
    pf_rd <= pf_mem[pf_ra];
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd <= q_mem[q_ra];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
    if (unp_we) unp_mem[unp_wa] <= unp_wd;
    unp_rd <= unp_mem[unp_ra];
  end

  // Decoded helpers
  logic [CntW-1:0] lim;
  logic            bad_var, pk_ok, up_ok, last_i, skip;
  logic [DegW-1:0] deg;
  logic [IdW-1:0]  vxor;
  logic [IdW-1:0]  s0, s1, s2, srt_k, var_k;
  logic [IdW-1:0]  t0, t1, t2;
  logic [CntW-1:0] stk_idx;

  assign lim     = (var_lim_i > CntW'(MaxVars)) ? CntW'(MaxVars) : var_lim_i;
  assign bad_var = ({1'b0, var_a_i} >= lim) || ({1'b0, var_b_i} >= lim) ||
                   ({1'b0, var_c_i} >= lim);
  assign pk_ok   = {1'b0, entry_index_i} < sc_q;
  assign up_ok   = {1'b0, entry_index_i} < ut_q;
  assign stk_idx = sc_q - CntW'(1) - {1'b0, entry_index_i};
  assign last_i  = i_q == CntW'(MaxEqs - 1);
  assign deg     = var_rd[VmW-1:IdW];
  assign vxor    = var_rd[IdW-1:0];
  assign var_k   = vars_q[k_q];

  // Three-element sorting network over the peeled equation's variables
  always_comb begin
    t0 = vars_q[0];
    t1 = vars_q[1];
    t2 = vars_q[2];
    if (t0 > t1) begin
      t0 = vars_q[1];
      t1 = vars_q[0];
    end
    s2 = (t1 > t2) ? t1 : t2;
    s1 = (t1 > t2) ? t2 : t1;
    s0 = t0;
    if (s0 > s1) begin
      s0 = s1;
      s1 = t0;
    end
  end

  always_comb begin
    case (k_q)
      2'd0:    srt_k = s0;
      2'd1:    srt_k = s1;
      default: srt_k = s2;
    endcase
    case (k_q)
      2'd1:    skip = s1 == s0;
      2'd2:    skip = s2 == s1;
      default: skip = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_BOOT:   if (last_i) state_d = S_IDLE;
      S_IDLE: begin
        if (req_valid_i) begin
          unique case (req_type_i)
            ReqClear:    state_d = S_CLR;
            ReqLoad:     state_d = bad_var ? S_RESP : S_LD_CHK;
            ReqPeel:     state_d = S_PZ;
            ReqRdPeeled: state_d = pk_ok ? S_RDW : S_RESP;
            ReqRdUnpeel: state_d = up_ok ? S_RDW : S_RESP;
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_CLR:    if (last_i) state_d = S_RESP;
      S_LD_CHK: state_d = S_RESP;
      S_RDW:    state_d = S_RESP;
      S_RESP:   if (res_ready_i) state_d = S_IDLE;
      S_PZ:     if (last_i) state_d = S_B_LO;
      S_B_LO:   state_d = (n_q < lc_q) ? S_B_EQ : S_SC;
      S_B_EQ:   state_d = S_B_VL;
      S_B_VL:   state_d = S_B_RD;
      S_B_RD:   state_d = S_B_WR;
      S_B_WR:   state_d = (k_q == 2'(Slots - 1)) ? S_B_LO : S_B_RD;
      S_SC:     state_d = (v_q < lim) ? S_SC_CK : S_U_LO;
      S_SC_CK:  state_d = (deg == DegW'(1)) ? S_Q_POP : S_SC;
      S_Q_POP:  state_d = (head_q < tail_q) ? S_Q_V : S_SC;
      S_Q_V:    state_d = S_Q_CK;
      S_Q_CK:   state_d = (deg == DegW'(1) && sc_q < CntW'(MaxEqs)) ? S_P_VL : S_Q_POP;
      S_P_VL:   state_d = S_P_RD;
      S_P_RD:   state_d = S_P_WR;
      S_P_WR:   state_d = (k_q == 2'(Slots - 1)) ? S_E_RD : S_P_RD;
      S_E_RD: begin
        if (k_q == 2'(Slots)) state_d = S_Q_POP;
        else if (!skip) state_d = S_E_CK;
      end
      S_E_CK:   state_d = S_E_RD;
      S_U_LO:   state_d = (n_q < lc_q) ? S_U_FL : S_RESP;
      S_U_FL:   state_d = S_U_CK;
      S_U_CK:   state_d = S_U_LO;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    i_d = i_q; n_d = n_q; v_d = v_q; head_d = head_q; tail_d = tail_q;
    lc_d = lc_q; sc_d = sc_q; ut_d = ut_q; k_d = k_q;
    e_d = e_q; qv_d = qv_q; vars_d = vars_q; req_d = req_q;
    st_d = st_q; eq_d = eq_q; var_d = var_q;
    eqv_we = 1'b0; eqv_wa = '0; eqv_wd = '0; eqv_ra = '0;
    pres_we = 1'b0; pres_wa = '0; pres_wd = 1'b0; pres_ra = '0;
    lo_we = 1'b0; lo_wa = '0; lo_wd = '0; lo_ra = '0;
    var_we = 1'b0; var_wa = '0; var_wd = '0; var_ra = '0;
    pf_we = 1'b0; pf_wa = '0; pf_wd = 1'b0; pf_ra = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
    unp_we = 1'b0; unp_wa = '0; unp_wd = '0; unp_ra = '0;
    unique case (state_q)
      S_BOOT, S_CLR: begin
        pres_we = 1'b1;
        pres_wa = i_q[IdW-1:0];
        i_d     = i_q + CntW'(1);
        if (last_i) begin
          lc_d = '0; sc_d = '0; ut_d = '0;
        end
      end
      S_IDLE: begin
        i_d   = '0;
        req_d = req_type_i;
        st_d  = StOk;
        eq_d  = '0;
        var_d = '0;
        e_d   = equation_number_i;
        vars_d = {var_c_i, var_b_i, var_a_i};
        pres_ra = equation_number_i;
        stk_ra  = stk_idx[IdW-1:0];
        unp_ra  = entry_index_i;
        if (req_valid_i) begin
          unique case (req_type_i)
            ReqLoad:     if (bad_var) st_d = StVarRange;
            ReqRdPeeled: if (!pk_ok) st_d = StIdxRange;
            ReqRdUnpeel: if (!up_ok) st_d = StIdxRange;
            default: ;
          endcase
        end
      end
      S_LD_CHK: begin
        if (pres_rd || lc_q >= CntW'(MaxEqs)) begin
          st_d = StFull;
        end else begin
          pres_we = 1'b1; pres_wa = e_q; pres_wd = 1'b1;
          lo_we = 1'b1; lo_wa = lc_q[IdW-1:0]; lo_wd = e_q;
          eqv_we = 1'b1; eqv_wa = e_q; eqv_wd = vars_q;
          lc_d = lc_q + CntW'(1);
          sc_d = '0; ut_d = '0;
        end
      end
      S_RDW: begin
        if (req_q == ReqRdPeeled) begin
          eq_d  = stk_rd[IdW-1:0];
          var_d = stk_rd[2*IdW-1:IdW];
        end else begin
          eq_d = unp_rd;
        end
      end
      S_RESP: ;
      S_PZ: begin
        var_we = 1'b1; var_wa = i_q[IdW-1:0];
        pf_we  = 1'b1; pf_wa  = i_q[IdW-1:0];
        i_d = i_q + CntW'(1);
        sc_d = '0; ut_d = '0; n_d = '0;
      end
      S_B_LO: begin
        lo_ra = n_q[IdW-1:0];
        v_d   = '0;
      end
      S_B_EQ: begin
        e_d    = lo_rd;
        eqv_ra = lo_rd;
      end
      S_B_VL, S_P_VL: begin
        vars_d = eqv_rd;
        k_d    = '0;
      end
      S_B_RD, S_P_RD: var_ra = var_k;
      S_B_WR: begin
        var_we = 1'b1; var_wa = var_k;
        var_wd = {deg + DegW'(1), vxor ^ e_q};
        if (k_q == 2'(Slots - 1)) n_d = n_q + CntW'(1);
        else k_d = k_q + 2'd1;
      end
      S_SC: begin
        var_ra = v_q[IdW-1:0];
        n_d    = '0;
      end
      S_SC_CK: begin
        if (deg == DegW'(1)) begin
          q_we = 1'b1; q_wa = '0; q_wd = v_q[IdW-1:0];
          head_d = '0; tail_d = CntW'(1);
        end else begin
          v_d = v_q + CntW'(1);
        end
      end
      S_Q_POP: begin
        q_ra = head_q;
        if (head_q < tail_q) head_d = head_q + CntW'(1);
        else v_d = v_q + CntW'(1);
      end
      S_Q_V: begin
        qv_d   = q_rd;
        var_ra = q_rd;
      end
      S_Q_CK: begin
        eqv_ra = vxor;
        if (deg == DegW'(1) && sc_q < CntW'(MaxEqs)) begin
          e_d = vxor;
          stk_we = 1'b1; stk_wa = sc_q[IdW-1:0]; stk_wd = {qv_q, vxor};
          pf_we = 1'b1; pf_wa = vxor; pf_wd = 1'b1;
          sc_d = sc_q + CntW'(1);
        end
      end
      S_P_WR: begin
        var_we = 1'b1; var_wa = var_k;
        var_wd = {(deg != '0) ? deg - DegW'(1) : deg,
                  (var_k != qv_q) ? vxor ^ e_q : vxor};
        if (k_q == 2'(Slots - 1)) k_d = '0;
        else k_d = k_q + 2'd1;
      end
      S_E_RD: begin
        var_ra = srt_k;
        if (k_q != 2'(Slots) && skip) k_d = k_q + 2'd1;
      end
      S_E_CK: begin
        if (deg == DegW'(1) && tail_q < CntW'(QDepth)) begin
          q_we = 1'b1; q_wa = tail_q; q_wd = srt_k;
          tail_d = tail_q + CntW'(1);
        end
        k_d = k_q + 2'd1;
      end
      S_U_LO: lo_ra = n_q[IdW-1:0];
      S_U_FL: begin
        e_d   = lo_rd;
        pf_ra = lo_rd;
      end
      S_U_CK: begin
        if (!pf_rd) begin
          unp_we = 1'b1; unp_wa = ut_q[IdW-1:0]; unp_wd = e_q;
          ut_d = ut_q + CntW'(1);
        end
        n_d = n_q + CntW'(1);
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
      i_q <= '0; n_q <= '0; v_q <= '0; head_q <= '0; tail_q <= '0;
      lc_q <= '0; sc_q <= '0; ut_q <= '0; k_q <= '0; req_q <= ReqClear;
    end else begin
      state_q <= state_d;
      i_q <= i_d; n_q <= n_d; v_q <= v_d; head_q <= head_d; tail_q <= tail_d;
      lc_q <= lc_d; sc_q <= sc_d; ut_q <= ut_d; k_q <= k_d; req_q <= req_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    e_q <= e_d; qv_q <= qv_d; vars_q <= vars_d;
    st_q <= st_d; eq_q <= eq_d; var_q <= var_d;
  end

  assign req_ready_o = state_q == S_IDLE;
  assign res_valid_o = state_q == S_RESP;
  assign res_o = '{status: st_q, peeled_count: sc_q, unpeeled_count: ut_q,
                   equation_out: eq_q, variable_out: var_q};

`ifndef SYNTHESIS
  a_sc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_q <= CntW'(MaxEqs)) else $error("stack count overflow");
  a_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("worklist head passed tail");
  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= CntW'(QDepth)) else $error("worklist overflow");
  a_lc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lc_q <= CntW'(MaxEqs)) else $error("load count overflow");
`endif

endmodule

>>> rtl/core/hypergraph_peeler.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | req_type, equation_number, var_a..c, entry_index
// out     | output    | out_valid_o/out_ready_i | status, counts, equation_out, variable_out
// cfg     | input     | cfg_we_i              | cfg_data_i (variables_in_use)
// One transaction at a time. Loads and reads that fail their range checks are rejected at once.
// Clear sweeps the presence memory. Peel: a zeroing sweep, a pass over each loaded equation to rebuild
// the degree/XOR memory, a scan over the variables, the peeling of each equation, a check of each
// worklist entry not peeled, and a pass over the loaded equations for the unpeeled list.
// After reset a pass clears the presence memory before the first input.
// The output register lets the next input be taken while a result waits.
module hypergraph_peeler import hgp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      req_type_i,
  input  logic [IdW-1:0]  equation_number_i,
  input  logic [IdW-1:0]  var_a_i,
  input  logic [IdW-1:0]  var_b_i,
  input  logic [IdW-1:0]  var_c_i,
  input  logic [IdW-1:0]  entry_index_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic [CntW-1:0] peeled_count_o,
  output logic [CntW-1:0] unpeeled_count_o,
  output logic [IdW-1:0]  equation_out_o,
  output logic [IdW-1:0]  variable_out_o
);

  logic [CntW-1:0] lim_q;
  logic            ov_q, ov_d, res_valid, res_ready;
  hgp_res_t        res, out_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lim_q <= CntW'(MaxVars);
    else if (cfg_we_i) lim_q <= cfg_data_i;
  end

  hgp_core u_core (
    .clk_i, .rst_ni,
    .var_lim_i (lim_q),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_type_i, .equation_number_i, .var_a_i, .var_b_i, .var_c_i, .entry_index_i,
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o (res)
  );

  // Output register
  assign res_ready = !ov_q || out_ready_i;
  always_comb begin
    ov_d = ov_q;
    if (out_ready_i) ov_d = 1'b0;
    if (res_valid && res_ready) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else ov_q <= ov_d;
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign out_valid_o      = ov_q;
  assign status_o         = out_q.status;
  assign peeled_count_o   = out_q.peeled_count;
  assign unpeeled_count_o = out_q.unpeeled_count;
  assign equation_out_o   = out_q.equation_out;
  assign variable_out_o   = out_q.variable_out;

endmodule

>>> tb/hypergraph_peeler_tb.sv
module hypergraph_peeler_tb;
  import hgp_pkg::*;

  // Stimulus row: request fields plus an optional hand-written expectation
  typedef struct {
    logic [2:0]     req;
    logic [IdW-1:0] eqn;
    logic [IdW-1:0] va;
    logic [IdW-1:0] vb;
    logic [IdW-1:0] vc;
    logic [IdW-1:0] idx;
    bit             fixed;
    hgp_res_t       res;
  } stim_row_t;

  localparam logic [2:0] ReqSpare5 = 3'd5;
  localparam logic [2:0] ReqSpare6 = 3'd6;
  localparam logic [2:0] ReqSpare7 = 3'd7;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CntW-1:0] cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [2:0]      req_type_i = '0;
  logic [IdW-1:0]  equation_number_i = '0;
  logic [IdW-1:0]  var_a_i = '0;
  logic [IdW-1:0]  var_b_i = '0;
  logic [IdW-1:0]  var_c_i = '0;
  logic [IdW-1:0]  entry_index_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [1:0]      status_o;
  logic [CntW-1:0] peeled_count_o;
  logic [CntW-1:0] unpeeled_count_o;
  logic [IdW-1:0]  equation_out_o;
  logic [IdW-1:0]  variable_out_o;

  // Shadow copy of the equation store and peel results
  int unsigned vars_in_use;
  int unsigned eq_vars [MaxEqs][Slots];
  bit          eq_present [MaxEqs];
  int unsigned load_seq [MaxEqs];
  int unsigned load_cnt;
  int unsigned deg [MaxVars];
  int unsigned vxor [MaxVars];
  bit          peeled [MaxEqs];
  int unsigned solved_var [MaxEqs];
  int unsigned solved_eq [MaxEqs];
  int unsigned solved_cnt;
  int unsigned unpeeled_ids [MaxEqs];
  int unsigned unpeeled_cnt;

  hgp_res_t    exp_res_q [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatch_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 49;

  hypergraph_peeler i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .equation_number_i(equation_number_i),
    .var_a_i          (var_a_i),
    .var_b_i          (var_b_i),
    .var_c_i          (var_c_i),
    .entry_index_i    (entry_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .peeled_count_o   (peeled_count_o),
    .unpeeled_count_o (unpeeled_count_o),
    .equation_out_o   (equation_out_o),
    .variable_out_o   (variable_out_o)
  );

  // Clock: period 8
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Append to the scoreboard and to the directed table
  function automatic void queue_expected(hgp_res_t res);
    exp_res_q.insert(exp_res_q.size(), res);
  endfunction

  function automatic void queue_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic int unsigned var_limit();
    return (vars_in_use < MaxVars) ? vars_in_use : MaxVars;
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < MaxEqs; i++) begin
      eq_present[i] = 1'b0;
      peeled[i]     = 1'b0;
    end
    for (int i = 0; i < MaxVars; i++) begin
      deg[i]  = 0;
      vxor[i] = 0;
    end
    load_cnt     = 0;
    solved_cnt   = 0;
    unpeeled_cnt = 0;
  endfunction

  // Worklist peel from one degree-one variable
  function automatic void peel_from(int unsigned start);
    int unsigned wq [QDepth];
    int unsigned head, tail;
    int unsigned v, e, t;
    int unsigned srt [Slots];
    head = 0;
    tail = 0;
    wq[tail] = start;
    tail++;
    while (head < tail) begin
      v = wq[head];
      head++;
      if (deg[v] != 1) continue;
      e = vxor[v];
      if (e >= MaxEqs || solved_cnt >= MaxEqs) continue;
      solved_var[solved_cnt] = v;
      solved_eq[solved_cnt]  = e;
      solved_cnt++;
      peeled[e] = 1'b1;
      for (int k = 0; k < Slots; k++) begin
        srt[k] = eq_vars[e][k];
        if (deg[srt[k]] > 0) deg[srt[k]]--;
        if (srt[k] != v) vxor[srt[k]] ^= e;
      end
      for (int k = 1; k < Slots; k++)
        for (int j = k; j > 0 && srt[j-1] > srt[j]; j--) begin
          t = srt[j]; srt[j] = srt[j-1]; srt[j-1] = t;
        end
      for (int k = 0; k < Slots; k++) begin
        if (k > 0 && srt[k] == srt[k-1]) continue;
        if (deg[srt[k]] == 1 && tail < QDepth) begin
          wq[tail] = srt[k];
          tail++;
        end
      end
    end
  endfunction

  function automatic void run_peel();
    int unsigned e;
    for (int i = 0; i < MaxVars; i++) begin
      deg[i]  = 0;
      vxor[i] = 0;
    end
    for (int i = 0; i < MaxEqs; i++) peeled[i] = 1'b0;
    solved_cnt   = 0;
    unpeeled_cnt = 0;
    for (int n = 0; n < load_cnt; n++) begin
      e = load_seq[n];
      for (int k = 0; k < Slots; k++) begin
        deg[eq_vars[e][k]]++;
        vxor[eq_vars[e][k]] ^= e;
      end
    end
    for (int v = 0; v < var_limit(); v++)
      if (deg[v] == 1) peel_from(v);
    for (int n = 0; n < load_cnt; n++)
      if (!peeled[load_seq[n]]) begin
        unpeeled_ids[unpeeled_cnt] = load_seq[n];
        unpeeled_cnt++;
      end
  endfunction

  function automatic logic [1:0] load_equation(int unsigned e, int unsigned a,
                                               int unsigned b, int unsigned c);
    int unsigned vs [Slots];
    vs[0] = a; vs[1] = b; vs[2] = c;
    if (e >= MaxEqs) return StIdxRange;
    for (int k = 0; k < Slots; k++)
      if (vs[k] >= var_limit()) return StVarRange;
    if (load_cnt >= MaxEqs || eq_present[e]) return StFull;
    eq_present[e] = 1'b1;
    load_seq[load_cnt] = e;
    load_cnt++;
    for (int k = 0; k < Slots; k++) begin
      eq_vars[e][k] = vs[k];
      deg[vs[k]]++;
      vxor[vs[k]] ^= e;
    end
    solved_cnt   = 0;
    unpeeled_cnt = 0;
    return StOk;
  endfunction

  // Advance the shadow state by one request and return the expected response
  function automatic hgp_res_t predict_response(stim_row_t r);
    hgp_res_t res;
    int unsigned p;
    res = '0;
    case (r.req)
      ReqClear: clear_store();
      ReqLoad:  res.status = load_equation(r.eqn, r.va, r.vb, r.vc);
      ReqPeel:  run_peel();
      ReqRdPeeled: begin
        if (r.idx < solved_cnt) begin
          p = solved_cnt - 1 - r.idx;
          res.equation_out = IdW'(solved_eq[p]);
          res.variable_out = IdW'(solved_var[p]);
        end else begin
          res.status = StIdxRange;
        end
      end
      ReqRdUnpeel: begin
        if (r.idx < unpeeled_cnt) res.equation_out = IdW'(unpeeled_ids[r.idx]);
        else res.status = StIdxRange;
      end
      default: ;
    endcase
    res.peeled_count   = CntW'(solved_cnt);
    res.unpeeled_count = CntW'(unpeeled_cnt);
    return res;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, field, got, want);
    mismatch_cnt++;
  endtask

  // Present one transaction; random idle gaps may be inserted before it
  task automatic send_request(stim_row_t r);
    hgp_res_t res;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    req_type_i        = r.req;
    equation_number_i = r.eqn;
    var_a_i           = r.va;
    var_b_i           = r.vb;
    var_c_i           = r.vc;
    entry_index_i     = r.idx;
    do @(posedge clk_i); while (!in_ready_o);
    res = predict_response(r);
    queue_expected(r.fixed ? r.res : res);
    sent_cnt++;
    if (sent_cnt == 520) begin
      send_idle_pct = 49;
      recv_idle_pct = 37;
    end else if (sent_cnt == 1040) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    // transaction taken, drop valid so no copy is sent while the caller waits
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic stim_row_t make_row(logic [2:0] req, int unsigned eqn, int unsigned va,
                                         int unsigned vb, int unsigned vc, int unsigned idx);
    stim_row_t r;
    r.req = req;
    r.eqn = IdW'(eqn);
    r.va  = IdW'(va);
    r.vb  = IdW'(vb);
    r.vc  = IdW'(vc);
    r.idx = IdW'(idx);
    r.fixed = 1'b0;
    r.res   = '0;
    return r;
  endfunction

  function automatic void add_fixed(logic [2:0] req, int unsigned eqn, int unsigned va,
                                    int unsigned vb, int unsigned vc, int unsigned idx,
                                    logic [1:0] st, int unsigned pc, int unsigned uc);
    stim_row_t r;
    r = make_row(req, eqn, va, vb, vc, idx);
    r.fixed = 1'b1;
    r.res.status         = st;
    r.res.peeled_count   = CntW'(pc);
    r.res.unpeeled_count = CntW'(uc);
    queue_row(r);
  endfunction

  // Register write while the block is idle
  task automatic write_limit(int unsigned val);
    wait (exp_res_q.size() == 0);
    repeat (20) @(negedge clk_i);
    in_valid_i = 1'b0;
    cfg_we_i   = 1'b1;
    cfg_data_i = CntW'(val);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    vars_in_use = val & 11'h7FF;
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Response checker
  always @(posedge clk_i) begin
    hgp_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_res_q.size() == 0) begin
        report_mismatch("unexpected response", 0, 0);
      end else begin
        want = exp_res_q.pop_front();
        if (status_o != want.status) report_mismatch("status", status_o, want.status);
        if (peeled_count_o != want.peeled_count)
          report_mismatch("peeled_count", peeled_count_o, want.peeled_count);
        if (unpeeled_count_o != want.unpeeled_count)
          report_mismatch("unpeeled_count", unpeeled_count_o, want.unpeeled_count);
        if (equation_out_o != want.equation_out)
          report_mismatch("equation_out", equation_out_o, want.equation_out);
        if (variable_out_o != want.variable_out)
          report_mismatch("variable_out", variable_out_o, want.variable_out);
      end
    end
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned ids [MaxEqs];
    int unsigned n, vr, lim, t, j, lim_pick;
    stim_row_t r;
    vars_in_use = MaxVars;
    clear_store();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty reads, spare codes, loads, duplicates, peel, reads, clear
    add_fixed(ReqRdPeeled, 0, 0, 0, 0, 0, StIdxRange, 0, 0);
    add_fixed(ReqRdUnpeel, 0, 0, 0, 0, 1023, StIdxRange, 0, 0);
    add_fixed(ReqSpare5, 1023, 1023, 1023, 1023, 1023, StOk, 0, 0);
    add_fixed(ReqLoad, 0, 0, 1, 2, 0, StOk, 0, 0);
    add_fixed(ReqLoad, 0, 5, 6, 7, 0, StFull, 0, 0);
    add_fixed(ReqLoad, 1023, 1023, 1023, 1023, 0, StOk, 0, 0);
    queue_row(make_row(ReqLoad, 5, 3, 3, 4, 0));
    queue_row(make_row(ReqLoad, 7, 2, 4, 8, 0));
    queue_row(make_row(ReqLoad, 9, 8, 8, 8, 0));
    queue_row(make_row(ReqPeel, 0, 0, 0, 0, 0));
    queue_row(make_row(ReqRdPeeled, 0, 0, 0, 0, 0));
    queue_row(make_row(ReqRdPeeled, 0, 0, 0, 0, 1));
    queue_row(make_row(ReqRdPeeled, 0, 0, 0, 0, 1023));
    queue_row(make_row(ReqRdUnpeel, 0, 0, 0, 0, 0));
    queue_row(make_row(ReqPeel, 0, 0, 0, 0, 0));
    queue_row(make_row(ReqSpare6, 0, 0, 0, 0, 0));
    queue_row(make_row(ReqSpare7, 0, 0, 0, 0, 2));
    // load after peel drops the peel result
    queue_row(make_row(ReqLoad, 512, 0, 0, 1, 0));
    queue_row(make_row(ReqRdPeeled, 0, 0, 0, 0, 0));
    add_fixed(ReqClear, 0, 0, 0, 0, 0, StOk, 0, 0);
    add_fixed(ReqRdUnpeel, 0, 0, 0, 0, 0, StIdxRange, 0, 0);
    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Full store: all ids loaded at full variable range, then peeled
    write_limit(MaxVars);
    send_request(make_row(ReqClear, 0, 0, 0, 0, 0));
    for (int i = 0; i < MaxEqs; i++) ids[i] = i;
    for (int i = MaxEqs - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ids[i]; ids[i] = ids[j]; ids[j] = t;
    end
    for (int i = 0; i < MaxEqs; i++)
      send_request(make_row(ReqLoad, ids[i], $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 1023), 0));
    send_request(make_row(ReqLoad, $urandom_range(0, 1023), 1, 2, 3, 0));
    send_request(make_row(ReqPeel, 0, 0, 0, 0, 0));
    // hold off until the peel result is back
    wait (exp_res_q.size() == 0);
    send_request(make_row(ReqRdPeeled, 0, 0, 0, 0, 0));
    send_request(make_row(ReqRdPeeled, 0, 0, 0, 0, 1023));
    send_request(make_row(ReqRdUnpeel, 0, 0, 0, 0, 1023));
    send_request(make_row(ReqRdUnpeel, 0, 0, 0, 0, 0));

    // Random rounds: optional limit change and clear, loads, peel, reads, noise
    while (sent_cnt < 1560) begin
      if ($urandom_range(0, 3) == 0) begin
        lim_pick = $urandom_range(0, 5);
        case (lim_pick)
          0: write_limit(1);
          1: write_limit(MaxVars);
          2: write_limit($urandom_range(1, 8));
          default: write_limit($urandom_range(1, MaxVars));
        endcase
      end
      if ($urandom_range(0, 3) != 0) send_request(make_row(ReqClear, 0, 0, 0, 0, 0));
      lim = var_limit();
      n   = $urandom_range(1, 24);
      vr  = (2 * n + 3 < lim) ? 2 * n + 3 : lim;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0)
          r = make_row(ReqLoad, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
        else
          r = make_row(ReqLoad, $urandom_range(0, 1023), $urandom_range(0, vr - 1),
                       $urandom_range(0, vr - 1), $urandom_range(0, vr - 1), 0);
        send_request(r);
      end
      send_request(make_row(ReqPeel, 0, 0, 0, 0, 0));
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        t = $urandom_range(0, 9);
        if (t < 4)
          r = make_row(ReqRdPeeled, 0, 0, 0, 0, $urandom_range(0, solved_cnt + 1));
        else if (t < 8)
          r = make_row(ReqRdUnpeel, 0, 0, 0, 0, $urandom_range(0, unpeeled_cnt + 1));
        else
          r = make_row(3'($urandom_range(2, 7)), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 1023));
        send_request(r);
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (exp_res_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
